>>> rtl/assert_macros.svh
// assertion helpers for the palette block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/pnc_pkg.sv
package pnc_pkg;

	localparam int PAL_ENTRIES = 256;
	localparam int PAL_AW = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
	localparam int DIST_W = 18;
	localparam logic [DIST_W-1:0] START_DIST = DIST_W'(256 * 256 * 3);

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUANT = 1'b1;

	typedef struct packed {
		logic start;
		logic write;
		logic issue;
		logic load_out;
	} pnc_cmd_t;

	typedef struct packed {
		logic addr_last;
		logic pipe_busy;
		logic out_full;
	} pnc_sts_t;

endpackage

>>> rtl/palette_nearest_color_top.sv
// channel  | direction | signals                               | payload
// s        | in        | s_tvalid s_tready s_tdata s_tuser     | request, write or quantize
// m        | out       | m_tvalid m_tready m_tdata             | nearest palette index
//
// a write transaction stores its entry at the accepting edge
// a quantize transaction makes one palette read per cycle
// through the single memory read port, then a two-stage square and compare drain
// s_tready is high only while no quantize is in progress; a waiting result does
// not block the next transaction, only the load of the following result
// reset clears the palette valid bits at once, no clearing pass is needed
`include "assert_macros.svh"

module palette_nearest_color_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // entry_index, red, green, blue
	input  logic        s_tuser,  // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // color_index
);

	pnc_pkg::pnc_cmd_t cmd;
	pnc_pkg::pnc_sts_t sts;

	pnc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pnc_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

	`ASSERT_IMP(a_busy_not_ready, clk, arst_n, sts.pipe_busy, !s_tready)
	`ASSERT_IMP(a_load_has_room, clk, arst_n, cmd.load_out, !m_tvalid || m_tready)
	`ASSERT_NEXT(a_quant_blocks, clk, arst_n, s_tvalid && s_tready && s_tuser, !s_tready)

endmodule

>>> rtl/pnc_ctrl.sv
module pnc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic              s_tuser,
	input  logic              m_tready,
	input  pnc_pkg::pnc_sts_t sts,
	output pnc_pkg::pnc_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d      = state_q;
		cmd.start    = 1'b0;
		cmd.write    = 1'b0;
		cmd.issue    = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser == pnc_pkg::REQ_QUANT) begin
						cmd.start = 1'b1;
						state_d   = ST_SCAN;
					end else begin
						cmd.write = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.addr_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy && (!sts.out_full || m_tready)) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/pnc_datapath.sv
module pnc_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [31:0]       s_tdata,
	input  pnc_pkg::pnc_cmd_t cmd,
	output pnc_pkg::pnc_sts_t sts,
	input  logic              m_tready,
	output logic              m_tvalid,
	output logic [7:0]        m_tdata
);

	localparam int AW = pnc_pkg::PAL_AW;
	localparam int DW = pnc_pkg::DIST_W;

	logic [23:0]            mem [pnc_pkg::PAL_ENTRIES];
	logic [pnc_pkg::PAL_ENTRIES-1:0] valid_q;

	logic [7:0]    red_q, green_q, blue_q;
	logic [AW-1:0] addr_q;

	logic [23:0]   rd_s1;
	logic          vld_s1;
	logic          en_s1;
	logic [AW-1:0] idx_s1;

	logic [15:0]   sq_r_s2, sq_g_s2, sq_b_s2;
	logic          en_s2;
	logic [AW-1:0] idx_s2;

	logic [DW-1:0] best_dist_q;
	logic [AW-1:0] best_idx_q;
	logic          out_valid_q;
	logic [7:0]    out_data_q;

	logic [23:0]   entry;
	logic [7:0]    d_r, d_g, d_b;
	logic [DW-1:0] sum_dist;
	logic [8:0]    wr_idx;
	logic          wr_ok;
	logic [AW-1:0] wr_addr;

	assign wr_idx  = {1'b0, s_tdata[7:0]};
	assign wr_ok   = cmd.write && (wr_idx < 9'(pnc_pkg::PAL_ENTRIES));
	assign wr_addr = AW'(s_tdata[7:0]);

	// palette store, one write and one read port
	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[wr_addr] <= {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};
		end
		rd_s1 <= mem[addr_q];
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_ok) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			red_q   <= s_tdata[15:8];
			green_q <= s_tdata[23:16];
			blue_q  <= s_tdata[31:24];
		end
		vld_s1 <= valid_q[addr_q];
		idx_s1 <= addr_q;
		idx_s2 <= idx_s1;
		sq_r_s2 <= 16'(d_r) * 16'(d_r);
		sq_g_s2 <= 16'(d_g) * 16'(d_g);
		sq_b_s2 <= 16'(d_b) * 16'(d_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			en_s1  <= 1'b0;
			en_s2  <= 1'b0;
		end else begin
			if (cmd.start) begin
				addr_q <= '0;
			end else if (cmd.issue) begin
				addr_q <= addr_q + AW'(1);
			end
			en_s1 <= cmd.issue;
			en_s2 <= en_s1;
		end
	end

	assign entry = vld_s1 ? rd_s1 : 24'd0;
	assign d_r = (entry[23:16] > red_q)   ? entry[23:16] - red_q   : red_q   - entry[23:16];
	assign d_g = (entry[15:8]  > green_q) ? entry[15:8]  - green_q : green_q - entry[15:8];
	assign d_b = (entry[7:0]   > blue_q)  ? entry[7:0]   - blue_q  : blue_q  - entry[7:0];
	assign sum_dist = DW'(sq_r_s2) + DW'(sq_g_s2) + DW'(sq_b_s2);

	// strict compare keeps the lowest index on a tie
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			best_dist_q <= pnc_pkg::START_DIST;
			best_idx_q  <= '0;
		end else if (en_s2 && (sum_dist < best_dist_q)) begin
			best_dist_q <= sum_dist;
			best_idx_q  <= idx_s2;
		end
		if (cmd.load_out) begin
			out_data_q <= 8'(best_idx_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.addr_last = (addr_q == AW'(pnc_pkg::PAL_ENTRIES - 1));
	assign sts.pipe_busy = en_s1 || en_s2;
	assign sts.out_full  = out_valid_q;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int RANDOM_ITEMS = 1630;
	localparam int CALM_ITEMS = 160;
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 1500;
	localparam int DRAIN_CYCLES = pnc_pkg::PAL_ENTRIES + 40;
	localparam int MAX_REPORTS = 10;

	class palette_model;
		logic [23:0] entry [256];
		logic [7:0] expected_indices [$];
		int mismatches;

		function new();
			foreach (entry[i])
				entry[i] = '0;
			mismatches = 0;
		endfunction

		function int unsigned distance(logic [23:0] e, logic [23:0] c);
			int unsigned sum;
			int d;
			sum = 0;
			for (int k = 0; k < 3; k++) begin
				d = int'(e[k*8 +: 8]) - int'(c[k*8 +: 8]);
				sum += d * d;
			end
			return sum;
		endfunction

		function logic [7:0] nearest_entry(logic [23:0] c);
			int unsigned best_dist;
			int unsigned cand_dist;
			int best;
			best = 0;
			best_dist = 3 * 256 * 256;
			for (int i = 0; i < pnc_pkg::PAL_ENTRIES && i < 256; i++) begin
				cand_dist = distance(entry[i], c);
				if (cand_dist < best_dist) begin
					best_dist = cand_dist;
					best = i;
				end
			end
			return 8'(best);
		endfunction

		function void note_request(logic req, logic [7:0] idx, logic [23:0] colour);
			if (req == pnc_pkg::REQ_WRITE) begin
				if (int'(idx) < pnc_pkg::PAL_ENTRIES)
					entry[idx] = colour;
			end else begin
				expected_indices.push_back(nearest_entry(colour));
			end
		endfunction

		function void check_index(logic [7:0] actual);
			logic [7:0] want;
			if (expected_indices.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: colour index %0d with none expected", $time, actual);
			end else begin
				want = expected_indices.pop_front();
				if (actual !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: colour index expected %0d, got %0d",
							$time, want, actual);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;  // entry_index, red, green, blue
	logic        s_tuser;  // req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;  // color_index

	palette_model model;
	bit hold_req = 1'b0;
	bit tx_idle = 1'b0;
	bit rx_idle = 1'b0;

	palette_nearest_color_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(40_000_000);
		$display("== FAIL ==");
		$finish;
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			model.check_index(m_tdata);

	// receiver side, including the long hold-off
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (rx_idle && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	task automatic send(logic req, logic [7:0] idx, logic [23:0] colour);
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {colour[7:0], colour[15:8], colour[23:16], idx};
		do @(posedge clk); while (!s_tready);
		model.note_request(req, idx, colour);
	endtask

	function automatic logic [7:0] corner_channel();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd127;
			3: return 8'd128;
			4: return 8'd254;
			default: return 8'd255;
		endcase
	endfunction

	function automatic logic [23:0] nudge(logic [23:0] c);
		logic [23:0] r;
		int v;
		for (int k = 0; k < 3; k++) begin
			v = int'(c[k*8 +: 8]) + int'($urandom_range(0, 6)) - 3;
			r[k*8 +: 8] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
		end
		return r;
	endfunction

	// writes copy existing entries now and then so that ties turn up
	task automatic random_item();
		logic [23:0] colour;
		logic [7:0] idx;
		logic req;
		idx = 8'($urandom_range(0, 255));
		req = ($urandom_range(0, 99) < 50) ? pnc_pkg::REQ_WRITE : pnc_pkg::REQ_QUANT;
		case ($urandom_range(0, 3))
			0, 1: colour = 24'($urandom);
			2: colour = {corner_channel(), corner_channel(), corner_channel()};
			default: begin
				colour = model.entry[$urandom_range(0, pnc_pkg::PAL_ENTRIES - 1)];
				if (req == pnc_pkg::REQ_QUANT)
					colour = nudge(colour);
			end
		endcase
		send(req, idx, colour);
	endtask

	initial begin
		model = new();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= pnc_pkg::REQ_WRITE;
		s_tdata <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(pnc_pkg::REQ_QUANT, 8'h00, 24'h000000);
		send(pnc_pkg::REQ_QUANT, 8'hff, 24'hffffff);
		send(pnc_pkg::REQ_WRITE, 8'hff, 24'hffffff);
		send(pnc_pkg::REQ_QUANT, 8'h00, 24'hffffff);
		send(pnc_pkg::REQ_WRITE, 8'h01, 24'hffffff);
		send(pnc_pkg::REQ_QUANT, 8'h5a, 24'hfefefe);
		send(pnc_pkg::REQ_WRITE, 8'h00, 24'hffffff);
		send(pnc_pkg::REQ_QUANT, 8'ha5, 24'h000000);
		send(pnc_pkg::REQ_WRITE, 8'h80, 24'h808080);
		send(pnc_pkg::REQ_QUANT, 8'h00, 24'h7f8081);
		send(pnc_pkg::REQ_WRITE, 8'h02, 24'hff0000);
		send(pnc_pkg::REQ_WRITE, 8'h03, 24'h00ff00);
		send(pnc_pkg::REQ_WRITE, 8'h04, 24'h0000ff);
		send(pnc_pkg::REQ_QUANT, 8'h00, 24'hff0000);
		send(pnc_pkg::REQ_QUANT, 8'h00, 24'h00ff00);
		send(pnc_pkg::REQ_QUANT, 8'h00, 24'h0000ff);
		send(pnc_pkg::REQ_WRITE, 8'h00, 24'h000000);
		send(pnc_pkg::REQ_QUANT, 8'hff, 24'h010101);

		tx_idle = 1'b1;
		rx_idle = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == HOLD_AT)
				hold_req = 1'b1;
			if (n == RANDOM_ITEMS - CALM_ITEMS) begin
				tx_idle = 1'b0;
				rx_idle = 1'b0;
			end
			random_item();
		end
		s_tvalid <= 1'b0;

		while (model.expected_indices.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (model.mismatches == 0 && model.expected_indices.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> palette_nearest_color_top.f
+incdir+rtl
rtl/pnc_pkg.sv
rtl/pnc_ctrl.sv
rtl/pnc_datapath.sv
rtl/palette_nearest_color_top.sv
sim/testbench.sv
